### hw/rtl/fpau_pkg.sv
// Shared types, codes and helpers for the Q-format fixed-point arithmetic unit.
// No dependencies.
`default_nettype none

package fpau_pkg;

  localparam int FRAC   = 8;             // fraction bits of the fixed-point raw value
  localparam int NUM_W  = 32 + FRAC;     // dividend width, a magnitude shifted up by FRAC
  localparam int EXP_OF = 127 - FRAC;    // float exponent offset from the leading-one index

  typedef enum logic [3:0] {
    ACT_FROM_INT   = 4'd0,
    ACT_FROM_FLOAT = 4'd1,
    ACT_TO_FLOAT   = 4'd2,
    ACT_TO_INT     = 4'd3,
    ACT_ADD        = 4'd4,
    ACT_SUB        = 4'd5,
    ACT_MUL        = 4'd6,
    ACT_DIV        = 4'd7,
    ACT_COMPARE    = 4'd8,
    ACT_MIN        = 4'd9,
    ACT_MAX        = 4'd10,
    ACT_INC        = 4'd11,
    ACT_DEC        = 4'd12
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_NAN  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REL_LT = 2'd0,
    REL_EQ = 2'd1,
    REL_GT = 2'd2
  } relation_t;

  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] res;
    logic        ovf;
  } sat_t;

  // Sign and magnitude to int32, saturating.
  function automatic sat_t sat_sm(input logic neg, input logic [63:0] mag);
    sat_t o;
    o.ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        o.ovf = 1'b1;
        o.res = MIN_NEG;
      end else begin
        o.res = 32'(0) - mag[31:0];
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        o.ovf = 1'b1;
        o.res = MAX_POS;
      end else begin
        o.res = mag[31:0];
      end
    end
    return o;
  endfunction

  // 33-bit two's complement sum to int32, saturating.
  function automatic sat_t sat33(input logic [32:0] s);
    sat_t o;
    o.ovf = (s[32] != s[31]);
    o.res = o.ovf ? (s[32] ? MIN_NEG : MAX_POS) : s[31:0];
    return o;
  endfunction

  typedef struct packed {
    logic        valid;
    action_t     act;
    logic [31:0] res;
    relation_t   rel;
    status_t     st;
    logic        neg_r;   // sign of product / quotient
    logic        neg_a;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        f_pend;  // float conversion still to finish
    logic        f_neg;
    logic [9:0]  f_sh;    // signed binary point shift
    logic [23:0] f_m;
  } s1_t;

  typedef struct packed {
    logic        valid;
    action_t     act;
    logic [31:0] res;
    relation_t   rel;
    status_t     st;
    logic        neg_r;
    logic        neg_a;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [63:0] prod;
    logic        f_pend;
    logic        f_neg;
    logic        f_ovf;
    logic [55:0] f_mag;
    logic        t_zero;
    logic [4:0]  t_p;
    logic [23:0] t_keep;
    logic        t_guard;
    logic        t_sticky;
  } s2_t;

  typedef struct packed {
    logic             valid;
    action_t          act;
    logic [31:0]      res;
    relation_t        rel;
    status_t          st;
    logic             neg;
    logic [NUM_W-1:0] num;   // dividend bits shift out, quotient bits shift in
    logic [31:0]      rem;
    logic [31:0]      den;
  } div_t;

endpackage

`default_nettype wire

### hw/rtl/fixed_point_arith_unit.sv
// Top level of the Q-format fixed-point arithmetic unit: a fully pipelined datapath.
// Depends on fpau_pkg.
`default_nettype none

// Channel  | Dir | Contents (lowest bit first)
// ---------+-----+----------------------------------------------------
// s_*      | in  | tuser: action[3:0]; tdata: operand_a[31:0], operand_b[31:0]
// m_*      | out | tdata: result[31:0], relation[1:0], status[1:0], 4'b0
//
// One item enters per cycle unless the pipe holds. The divider sets the
// length of the pipe: it is a chain of NUM_W restoring stages, one quotient
// bit each; all other actions finish in three stages and ride along the chain.
// The whole pipe moves as one: it holds when the output item is not taken,
// so nothing is dropped or repeated.
// Reset clears the valid bits only.

module fixed_point_arith_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
  input  wire logic [3:0]  s_tuser,   // action[3:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // result[31:0], relation[33:32], status[35:34]
);
  import fpau_pkg::*;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---------------- stage 1: decode, add/sub/compare, magnitudes ----------
  s1_t s1, s1_next;

  always_comb begin
    logic [31:0] a, b;
    logic [32:0] sum, dif, incv, decv;
    logic [31:0] tint;
    logic [7:0]  fexp, eexp;
    logic        lt, eq;
    sat_t        sv;
    a = s_tdata[31:0];
    b = s_tdata[63:32];
    sv = '0;
    s1_next = '0;
    s1_next.valid = s_tvalid;
    s1_next.act   = action_t'(s_tuser);
    s1_next.rel   = REL_LT;
    s1_next.st    = ST_OK;
    s1_next.res   = '0;
    s1_next.neg_a = a[31];
    s1_next.neg_r = a[31] ^ b[31];
    s1_next.mag_a = a[31] ? (32'(0) - a) : a;
    s1_next.mag_b = b[31] ? (32'(0) - b) : b;

    sum  = {a[31], a} + {b[31], b};
    dif  = {a[31], a} - {b[31], b};
    incv = {a[31], a} + 33'd1;
    decv = {a[31], a} - 33'd1;
    lt   = $signed(a) < $signed(b);
    eq   = (a == b);
    // truncate toward zero: bias negatives before the arithmetic shift
    tint = 32'($signed(a[31] ? (a + 32'((1 << FRAC) - 1)) : a) >>> FRAC);

    // float decode
    fexp = a[30:23];
    eexp = (fexp == 8'd0) ? 8'd1 : fexp;
    s1_next.f_neg = a[31];
    s1_next.f_m   = {fexp != 8'd0, a[22:0]};
    s1_next.f_sh  = {2'b00, eexp} - 10'd150 + 10'(FRAC);

    unique case (s1_next.act)
      ACT_FROM_INT: s1_next.res = a << FRAC;
      ACT_FROM_FLOAT: begin
        if (fexp == 8'hFF) begin
          if (a[22:0] != 23'd0) begin
            s1_next.st = ST_NAN;
          end else begin
            s1_next.st  = ST_OVF;
            s1_next.res = a[31] ? MIN_NEG : MAX_POS;
          end
        end else if (s1_next.f_m != 24'd0) begin
          s1_next.f_pend = 1'b1;
        end
      end
      ACT_TO_FLOAT: ;
      ACT_TO_INT: s1_next.res = tint;
      ACT_ADD: begin
        sv = sat33(sum);
        s1_next.res = sv.res;
        s1_next.st  = sv.ovf ? ST_OVF : ST_OK;
      end
      ACT_SUB: begin
        sv = sat33(dif);
        s1_next.res = sv.res;
        s1_next.st  = sv.ovf ? ST_OVF : ST_OK;
      end
      ACT_MUL: ;
      ACT_DIV: if (b == 32'd0) s1_next.st = ST_DIV0;
      ACT_COMPARE: s1_next.rel = lt ? REL_LT : (eq ? REL_EQ : REL_GT);
      ACT_MIN: s1_next.res = lt ? a : b;
      ACT_MAX: s1_next.res = (!lt && !eq) ? a : b;
      ACT_INC: begin
        sv = sat33(incv);
        s1_next.res = sv.res;
        s1_next.st  = sv.ovf ? ST_OVF : ST_OK;
      end
      ACT_DEC: begin
        sv = sat33(decv);
        s1_next.res = sv.res;
        s1_next.st  = sv.ovf ? ST_OVF : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1 <= s1_next;
    end
  end

  // ---------------- stage 2: multiply, float shift, leading one ----------
  s2_t s2, s2_next;

  always_comb begin
    logic [9:0]  s_neg;
    logic [55:0] rnd;
    logic [4:0]  p;
    logic [31:0] norm;
    s2_next = '0;
    s2_next.valid  = s1.valid;
    s2_next.act    = s1.act;
    s2_next.res    = s1.res;
    s2_next.rel    = s1.rel;
    s2_next.st     = s1.st;
    s2_next.neg_r  = s1.neg_r;
    s2_next.neg_a  = s1.neg_a;
    s2_next.mag_a  = s1.mag_a;
    s2_next.mag_b  = s1.mag_b;
    s2_next.f_pend = s1.f_pend;
    s2_next.f_neg  = s1.f_neg;
    s2_next.prod   = 64'(s1.mag_a) * 64'(s1.mag_b);

    // float to fixed magnitude, round half away from zero
    s_neg = 10'd0 - s1.f_sh;
    rnd   = '0;
    if (!s1.f_sh[9]) begin
      if (s1.f_sh > 10'd31) begin
        s2_next.f_ovf = 1'b1;
      end else begin
        s2_next.f_mag = 56'(s1.f_m) << s1.f_sh[4:0];
      end
    end else if (s_neg <= 10'd25) begin
      rnd = 56'(s1.f_m) + (56'd1 << (s_neg[4:0] - 5'd1));
      s2_next.f_mag = rnd >> s_neg[4:0];
    end

    // fixed to float: leading one and left alignment
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (s1.mag_a[i]) p = 5'(i);
    end
    norm = s1.mag_a << (5'd31 - p);
    s2_next.t_zero   = (s1.mag_a == 32'd0);
    s2_next.t_p      = p;
    s2_next.t_keep   = norm[31:8];
    s2_next.t_guard  = norm[7];
    s2_next.t_sticky = |norm[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (adv) begin
      s2 <= s2_next;
    end
  end

  // ---------------- stage 3: finish short actions, load the divider ------
  div_t dq [0:NUM_W];
  div_t d0_next;

  always_comb begin
    logic [24:0] kr;
    logic [5:0]  pe;
    logic [7:0]  fe;
    sat_t        sv;
    d0_next = '0;
    d0_next.valid = s2.valid;
    d0_next.act   = s2.act;
    d0_next.res   = s2.res;
    d0_next.rel   = s2.rel;
    d0_next.st    = s2.st;
    d0_next.neg   = s2.neg_r;
    d0_next.num   = {s2.mag_a, {FRAC{1'b0}}};
    d0_next.rem   = '0;
    d0_next.den   = s2.mag_b;

    kr = {1'b0, s2.t_keep} +
         25'(s2.t_guard && (s2.t_sticky || s2.t_keep[0]));
    pe = {1'b0, s2.t_p};
    if (kr[24]) begin
      kr = kr >> 1;
      pe = pe + 6'd1;
    end
    fe = 8'(pe) + 8'(EXP_OF);

    sv = '0;
    unique case (s2.act)
      ACT_FROM_FLOAT: begin
        if (s2.f_pend) begin
          if (s2.f_ovf) begin
            d0_next.res = s2.f_neg ? MIN_NEG : MAX_POS;
            d0_next.st  = ST_OVF;
          end else begin
            sv = sat_sm(s2.f_neg, 64'(s2.f_mag));
            d0_next.res = sv.res;
            d0_next.st  = sv.ovf ? ST_OVF : ST_OK;
          end
        end
      end
      ACT_TO_FLOAT: d0_next.res = s2.t_zero ? 32'd0 : {s2.neg_a, fe, kr[22:0]};
      ACT_MUL: begin
        sv = sat_sm(s2.neg_r, s2.prod >> FRAC);
        d0_next.res = sv.res;
        d0_next.st  = sv.ovf ? ST_OVF : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dq[0].valid <= 1'b0;
    end else if (adv) begin
      dq[0] <= d0_next;
    end
  end

  // ---------------- divider: one restoring step per stage ----------------
  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    div_t nx;
    always_comb begin
      logic [32:0] trial;
      logic        qb;
      nx    = dq[k];
      trial = {dq[k].rem, dq[k].num[NUM_W-1]};
      qb    = (trial >= {1'b0, dq[k].den});
      nx.rem = qb ? 32'(trial - {1'b0, dq[k].den}) : trial[31:0];
      nx.num = {dq[k].num[NUM_W-2:0], qb};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dq[k+1].valid <= 1'b0;
      end else if (adv) begin
        dq[k+1] <= nx;
      end
    end
  end

  // ---------------- output register --------------------------------------
  logic        out_valid;
  logic [31:0] out_res;
  relation_t   out_rel;
  status_t     out_st;
  logic [31:0] fin_res;
  status_t     fin_st;

  always_comb begin
    sat_t sv;
    sv      = sat_sm(dq[NUM_W].neg, 64'(dq[NUM_W].num));
    fin_res = dq[NUM_W].res;
    fin_st  = dq[NUM_W].st;
    if (dq[NUM_W].act == ACT_DIV && dq[NUM_W].st != ST_DIV0) begin
      fin_res = sv.res;
      fin_st  = sv.ovf ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dq[NUM_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= fin_res;
      out_rel <= dq[NUM_W].rel;
      out_st  <= fin_st;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_st, out_rel, out_res};

  // ---------------- checks -----------------------------------------------
  a_ovf_extreme: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_st == ST_OVF) |-> (out_res == MAX_POS || out_res == MIN_NEG))
    else $error("saturated result is not an extreme value");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_st == ST_NAN || out_st == ST_DIV0)) |-> (out_res == 32'd0))
    else $error("flagged result is not zero");

  a_div0_only_div: assert property (@(posedge clk) disable iff (rst)
    (dq[NUM_W].valid && dq[NUM_W].act != ACT_DIV) |-> (dq[NUM_W].st != ST_DIV0))
    else $error("divide by zero flag on another action");

  a_rel_only_cmp: assert property (@(posedge clk) disable iff (rst)
    (dq[NUM_W].valid && dq[NUM_W].act != ACT_COMPARE) |-> (dq[NUM_W].rel == REL_LT))
    else $error("relation set on a non-compare action");

endmodule

`default_nettype wire
